// ===== rtl/ctfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera target frame parser package
// Shared types, register indexes and constants for the frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ctfp_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [3:0] count_t;
    typedef logic [1:0] reg_index_t;

    // Register indexes on the configuration channel.
    localparam reg_index_t REG_HEADER_FIRST  = 2'd0;
    localparam reg_index_t REG_HEADER_SECOND = 2'd1;
    localparam reg_index_t REG_TAIL_BYTE     = 2'd2;

    // Register values after reset.
    localparam byte_t HEADER_FIRST_RESET  = 8'h2C;
    localparam byte_t HEADER_SECOND_RESET = 8'h12;
    localparam byte_t TAIL_BYTE_RESET     = 8'h5B;

    // A frame, header included, closes when it reaches this many bytes (7 to 15).
    localparam count_t MAX_FRAME_BYTES = 4'd10;

    // Frame byte counts at the header bytes and the smallest count at close
    // that leaves four payload bytes ahead of the closing byte.
    localparam count_t COUNT_HDR1      = 4'd1;
    localparam count_t COUNT_HDR2      = 4'd2;
    localparam count_t MIN_CLOSE_COUNT = 4'd7;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HDR1 = 4'b0010,
        PH_DATA = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef struct packed {
        byte_t header_first;
        byte_t header_second;
        byte_t tail_byte;
    } cfg_t;

    typedef struct packed {
        byte_t center_x;
        byte_t center_y;
        byte_t box_width;
        byte_t box_height;
        logic  closed_by_tail;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/ctfp_if.sv =====
// ----------------------------------------------------------------------------
// Camera target frame parser channels
// Valid/ready channels for received bytes, target results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctfp_rx_if;
    logic            valid;
    logic            ready;
    ctfp_pkg::byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ctfp_target_if;
    logic            valid;
    logic            ready;
    ctfp_pkg::byte_t center_x;
    ctfp_pkg::byte_t center_y;
    ctfp_pkg::byte_t box_width;
    ctfp_pkg::byte_t box_height;
    logic            closed_by_tail;

    modport source (output valid, output center_x, output center_y, output box_width,
                    output box_height, output closed_by_tail, input ready);
    modport sink   (input valid, input center_x, input center_y, input box_width,
                    input box_height, input closed_by_tail, output ready);
endinterface

interface ctfp_cfg_if;
    logic                 valid;
    logic                 ready;
    ctfp_pkg::reg_index_t index;
    ctfp_pkg::byte_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/camera_target_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Camera target frame parser
// Deframes a serial byte stream and reports target x, y, width and height.
// ----------------------------------------------------------------------------
// Result: the result is registered and shows in the cycle after the closing byte is taken.
// Throughput: one byte per cycle; the result register frees the input side
// whenever it is empty or being taken in the same cycle.
// Reset: asynchronous, active low; the parser goes idle with its history cleared
// and the header and tail registers take their default values.
`default_nettype none

module camera_target_frame_parser (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ctfp_rx_if.sink        rx,
    ctfp_target_if.source  target,
    ctfp_cfg_if.sink       cfg
);
    import ctfp_pkg::*;

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;

    logic    take;
    logic    res_valid;
    result_t res;

    assign rx.ready  = !out_valid_reg || target.ready;
    assign take      = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    ctfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RESET;
            cfg_reg.header_second <= HEADER_SECOND_RESET;
            cfg_reg.tail_byte     <= TAIL_BYTE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER_FIRST:  cfg_reg.header_first  <= cfg.data;
                REG_HEADER_SECOND: cfg_reg.header_second <= cfg.data;
                REG_TAIL_BYTE:     cfg_reg.tail_byte     <= cfg.data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (target.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign target.valid          = out_valid_reg;
    assign target.center_x       = out_reg.center_x;
    assign target.center_y       = out_reg.center_y;
    assign target.box_width      = out_reg.box_width;
    assign target.box_height     = out_reg.box_height;
    assign target.closed_by_tail = out_reg.closed_by_tail;

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid_reg)
        else $error("closed frame did not reach the result register");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !target.ready) |-> !rx.ready)
        else $error("byte taken while a pending result is stalled");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid_reg || target.ready))
        else $error("new result would overwrite a pending one");

endmodule

`default_nettype wire

// ===== rtl/ctfp_core.sv =====
// ----------------------------------------------------------------------------
// Camera target frame parser core
// Header hunt, payload collection and frame close detection, one byte per cycle while bytes are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ctfp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire ctfp_pkg::byte_t   rx_byte,
    input  wire ctfp_pkg::cfg_t    cfg,
    output logic                   res_valid,
    output ctfp_pkg::result_t      res
);
    import ctfp_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    count_t count_reg;
    count_t count_next;
    byte_t  recent_reg  [4];
    byte_t  recent_next [4];

    count_t count_inc;
    logic   is_tail;
    logic   full;

    assign count_inc = count_reg + 4'd1;
    assign is_tail   = (rx_byte == cfg.tail_byte);
    assign full      = (count_inc >= MAX_FRAME_BYTES);

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        recent_next = recent_reg;
        res_valid   = 1'b0;

        res.center_x       = recent_reg[0];
        res.center_y       = recent_reg[1];
        res.box_width      = recent_reg[2];
        res.box_height     = recent_reg[3];
        res.closed_by_tail = is_tail;

        if (take)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == cfg.header_first)
                    begin
                        phase_next = PH_HDR1;
                        count_next = COUNT_HDR1;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        recent_next = '{default: '0};
                    end
                end
                PH_HDR1:
                begin
                    if (rx_byte == cfg.header_second)
                    begin
                        phase_next = PH_DATA;
                        count_next = COUNT_HDR2;
                    end
                    else
                    begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        recent_next = '{default: '0};
                    end
                end
                PH_DATA:
                begin
                    count_next = count_inc;
                    if (!is_tail && !full)
                    begin
                        recent_next[0] = recent_reg[1];
                        recent_next[1] = recent_reg[2];
                        recent_next[2] = recent_reg[3];
                        recent_next[3] = rx_byte;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                        res_valid  = (count_inc >= MIN_CLOSE_COUNT);
                    end
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    recent_next = '{default: '0};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            recent_reg <= '{default: '0};
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            recent_reg <= recent_next;
        end
    end

    a_result_only_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (take && phase_reg == PH_DATA))
        else $error("result raised outside payload collection");

    a_close_enters_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (phase_reg == PH_DONE))
        else $error("frame close did not enter the swallow phase");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_DONE) |=> (phase_reg == PH_IDLE && count_reg == '0))
        else $error("byte after close did not return to idle");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("byte count not clear while idle");

endmodule

`default_nettype wire
